>>> rtl/spq_pkg.sv
// package for the sorted priority queue: sizes, codes, entry and transaction types
// no dependencies; every rtl file of the queue imports it
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int REM_W         = 5;
  localparam int OCC_W         = 5;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PURGE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_NONE  = 2'd3
  } status_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_SHIFT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]    value;
    logic signed [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // control broadcast to the row of cells
  typedef struct packed {
    cell_mode_t                      mode;
    logic signed [PRIORITY_BITS-1:0] key;
    entry_t                          new_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]                      op;
    logic signed [VALUE_BITS-1:0]    item_value;
    logic signed [PRIORITY_BITS-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]                      status;
    logic signed [VALUE_BITS-1:0]    popped_value;
    logic signed [PRIORITY_BITS-1:0] popped_priority;
    logic [REM_W-1:0]                removed_count;
    logic [OCC_W-1:0]                occupancy;
  } spq_out_t;

endpackage

>>> rtl/spq_cell.sv
// one slot of the sorted list: holds an entry, compares it with the broadcast key
// and moves data to or from its neighbors; depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               left_ge,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ge,
  output logic               eq
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   gt;

  // signed compare of the stored priority with the key
  assign eq = valid && ($signed(entry_r.prio) == $signed(ctl.key));
  assign gt = valid && ($signed(entry_r.prio) >  $signed(ctl.key));
  assign ge = gt || eq;

  // next entry: keep, take the new one, or take a neighbor's
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      MODE_HOLD: begin
        entry_nxt = entry_r;
      end
      MODE_PUSH: begin
        priority if (ge) begin
          entry_nxt = entry_r;
        end else if (left_ge) begin
          entry_nxt = ctl.new_entry;
        end else begin
          entry_nxt = left_entry;
        end
      end
      MODE_POP: begin
        entry_nxt = right_entry;
      end
      MODE_SHIFT: begin
        entry_nxt = gt ? entry_r : right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: command control, entry count and the
// row of spq_cell slots; depends on spq_pkg and spq_cell
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+-----------------------------------------
//  input    | start, busy, in_item    | transaction taken when start && !busy
//  result   | out_strobe, out_result  | one cycle strobe, no back pressure
//
// push, pop and the unused op code leave busy low; the result strobes in the
// cycle after the transaction, so these go back to back.
// purge removes one matching entry per cycle through the cell row shift and
// holds busy until no match is left; the result follows the last removal.
// synchronous active-low reset clears the count and control; slot contents
// are unknown until written and are only read below the count.
// the receiver cannot stall: every result is on the ports for exactly one cycle.
module sorted_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_strobe,
  output spq_pkg::spq_out_t out_result
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PURGE = 2'b10
  } state_t;

  state_t               state_r,   state_nxt;
  logic [CNT_W-1:0]     count_r,   count_nxt;
  logic [CNT_W-1:0]     rem_r,     rem_nxt;
  logic signed [PRIORITY_BITS-1:0] key_r, key_nxt;
  logic                 strobe_r,  strobe_nxt;
  spq_out_t             out_r,     out_nxt;

  cell_ctl_t            ctl;
  entry_t               entries [CAPACITY];
  logic [CAPACITY-1:0]  valid;
  logic [CAPACITY-1:0]  ge;
  logic [CAPACITY-1:0]  eq;
  logic                 accept;
  logic                 any_match;
  logic                 not_full;
  logic                 not_empty;

  assign busy      = (state_r == S_PURGE);
  assign accept    = start && !busy;
  assign any_match = |eq;
  assign not_full  = (count_r < CNT_W'(CAPACITY));
  assign not_empty = (count_r != '0);

  // occupied slots from the count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (CNT_W'(i) < count_r);
    end
  end

  // broadcast control for the cell row
  always_comb begin
    ctl.mode            = MODE_HOLD;
    ctl.key             = busy ? key_r : in_item.item_priority;
    ctl.new_entry.value = in_item.item_value;
    ctl.new_entry.prio  = in_item.item_priority;
    priority if (busy) begin
      if (any_match) begin
        ctl.mode = MODE_SHIFT;
      end
    end else if (accept && (in_item.op == OP_PUSH) && not_full) begin
      ctl.mode = MODE_PUSH;
    end else if (accept && (in_item.op == OP_POP) && not_empty) begin
      ctl.mode = MODE_POP;
    end
  end

  // row of cells, each talking to its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_g;
    if (g == 0) begin : g_head
      assign left_e = ctl.new_entry;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = entries[g-1];
      assign left_g = ge[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_e = entries[g];
    end else begin : g_inner
      assign right_e = entries[g+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (valid[g]),
      .left_ge     (left_g),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entries[g]),
      .ge          (ge[g]),
      .eq          (eq[g])
    );
  end

  // command sequencing, count and result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.status          = STAT_OK;
          out_nxt.popped_value    = '0;
          out_nxt.popped_priority = '0;
          out_nxt.removed_count   = '0;
          strobe_nxt              = 1'b1;
          unique case (op_t'(in_item.op))
            OP_PUSH: begin
              if (not_full) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                out_nxt.status = STAT_FULL;
              end
            end
            OP_POP: begin
              if (not_empty) begin
                count_nxt                = count_r - CNT_W'(1);
                out_nxt.popped_value     = entries[0].value;
                out_nxt.popped_priority  = entries[0].prio;
                out_nxt.removed_count    = REM_W'(1);
              end else begin
                out_nxt.status = STAT_EMPTY;
              end
            end
            OP_PURGE: begin
              strobe_nxt = 1'b0;
              key_nxt    = in_item.item_priority;
              rem_nxt    = '0;
              state_nxt  = S_PURGE;
            end
            OP_NOP: begin
              count_nxt = count_r;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          out_nxt.occupancy = OCC_W'(count_nxt);
        end
      end
      S_PURGE: begin
        if (any_match) begin
          count_nxt = count_r - CNT_W'(1);
          rem_nxt   = rem_r + CNT_W'(1);
        end else begin
          out_nxt.status          = (rem_r == '0) ? STAT_NONE : STAT_OK;
          out_nxt.popped_value    = '0;
          out_nxt.popped_priority = '0;
          out_nxt.removed_count   = REM_W'(rem_r);
          out_nxt.occupancy       = OCC_W'(count_r);
          strobe_nxt              = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while purge runs");

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.occupancy == OCC_W'(count_r)))
    else $error("reported occupancy differs from entry count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.op == OP_PUSH) && not_full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow the list");
`endif

endmodule

>>> tb/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sorted_priority_queue: directed and random push, pop,
// purge and unused-op transactions against a shadow sorted list; depends on spq_pkg
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1630;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  spq_in_t   in_item;
  logic      out_strobe;
  spq_out_t  out_result;

  // shadow copy of the queue contents, head in slot 0
  logic signed [VALUE_BITS-1:0]    held_val [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] held_pri [CAPACITY];
  int                              held_count;

  spq_out_t pending_results[$];
  spq_out_t want;
  int       errors;
  int       cycle_count;
  int       n_push, n_pop, n_purge, n_nop;
  int       n_full, n_empty, n_purge_hits, n_checked, peak_occupancy;
  bit       tight_stream;

  sorted_priority_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // apply one transaction to the shadow list and return the result it should give
  function automatic spq_out_t shadow_queue_op(input spq_in_t it);
    spq_out_t                        res;
    logic signed [PRIORITY_BITS-1:0] key;
    int                              pos;
    int                              keep;
    int                              purged;
    res = '0;
    key = it.item_priority;
    case (it.op)
      OP_PUSH: begin
        n_push++;
        if (held_count >= CAPACITY) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_count && held_pri[pos] >= key) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_val[i] = held_val[i-1];
            held_pri[i] = held_pri[i-1];
          end
          held_val[pos] = it.item_value;
          held_pri[pos] = key;
          held_count++;
        end
      end
      OP_POP: begin
        n_pop++;
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
          n_empty++;
        end else begin
          res.popped_value    = held_val[0];
          res.popped_priority = held_pri[0];
          for (int i = 1; i < held_count; i++) begin
            held_val[i-1] = held_val[i];
            held_pri[i-1] = held_pri[i];
          end
          held_count--;
          res.removed_count = REM_W'(1);
        end
      end
      OP_PURGE: begin
        n_purge++;
        keep   = 0;
        purged = 0;
        // drop matches and close up the gaps, order kept
        for (int i = 0; i < held_count; i++) begin
          if (held_pri[i] == key) begin
            purged++;
          end else begin
            held_val[keep] = held_val[i];
            held_pri[keep] = held_pri[i];
            keep++;
          end
        end
        held_count        = keep;
        res.removed_count = REM_W'(purged);
        if (purged == 0) begin
          res.status = STAT_NONE;
        end else begin
          n_purge_hits++;
        end
      end
      default: begin
        n_nop++;
      end
    endcase
    res.occupancy = OCC_W'(held_count);
    if (held_count > peak_occupancy) peak_occupancy = held_count;
    return res;
  endfunction

  function automatic spq_in_t mk_item(input op_t op, input logic [VALUE_BITS-1:0] v,
                                      input logic [PRIORITY_BITS-1:0] p);
    spq_in_t it;
    it.op            = op;
    it.item_value    = v;
    it.item_priority = p;
    return it;
  endfunction

  // idle gap before a transaction: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tight_stream || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // priorities cluster on a few values so ties and purge hits are common
  function automatic logic [PRIORITY_BITS-1:0] random_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return PRIORITY_BITS'($urandom_range(0, 4)) - PRIORITY_BITS'(2);
    if (r == 6) return {1'b0, {(PRIORITY_BITS-1){1'b1}}};
    if (r == 7) return {1'b1, {(PRIORITY_BITS-1){1'b0}}};
    return PRIORITY_BITS'($urandom());
  endfunction

  function automatic spq_in_t random_item(input bit filling);
    spq_in_t it;
    int      r;
    int      push_weight;
    it.item_value    = VALUE_BITS'($urandom());
    it.item_priority = random_prio();
    push_weight      = filling ? 65 : 20;
    r                = $urandom_range(0, 99);
    if (r < push_weight) begin
      it.op = OP_PUSH;
    end else if (r < 80) begin
      it.op = OP_POP;
    end else if (r < 96) begin
      it.op = OP_PURGE;
      // usually purge a priority that is actually stored
      if (held_count > 0 && $urandom_range(0, 3) != 0)
        it.item_priority = held_pri[$urandom_range(0, held_count - 1)];
    end else begin
      it.op = OP_NOP;
    end
    return it;
  endfunction

  // send one transaction; start stays high across back-to-back items
  task automatic send_item(input spq_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(shadow_queue_op(it));
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker: every strobed transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("status", 32'(want.status), 32'(out_result.status));
        check_field("popped_value", 32'(want.popped_value), 32'(out_result.popped_value));
        check_field("popped_priority", 32'(want.popped_priority),
                    32'(out_result.popped_priority));
        check_field("removed_count", 32'(want.removed_count), 32'(out_result.removed_count));
        check_field("occupancy", 32'(want.occupancy), 32'(out_result.occupancy));
      end
    end
  end

  // pop, purge and unused op on an empty queue
  task automatic test_empty_queue();
    send_item(mk_item(OP_POP, 32'h0, 16'h0));
    send_item(mk_item(OP_PURGE, 32'h0, 16'h7FFF));
    send_item(mk_item(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  // fill with extreme values, signed order and ties, then push into a full queue
  task automatic test_fill_order_full();
    send_item(mk_item(OP_PUSH, 32'h0000_0005, 16'h0005));
    send_item(mk_item(OP_PUSH, 32'h8000_0000, 16'h8000));
    send_item(mk_item(OP_PUSH, 32'h7FFF_FFFF, 16'h7FFF));
    send_item(mk_item(OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk_item(OP_PUSH, 32'h0000_0006, 16'h0005));
    send_item(mk_item(OP_PUSH, 32'h0000_0000, 16'h0000));
    send_item(mk_item(OP_PUSH, 32'h5555_5555, 16'h5555));
    send_item(mk_item(OP_PUSH, 32'hAAAA_AAAA, 16'hAAAA));
    send_item(mk_item(OP_PUSH, 32'h0000_0007, 16'h0005));
    send_item(mk_item(OP_PUSH, 32'h1234_5678, 16'h0001));
    send_item(mk_item(OP_PUSH, 32'hFFFF_FFFB, 16'hFFFB));
    send_item(mk_item(OP_PUSH, 32'h0000_4000, 16'h4000));
    send_item(mk_item(OP_PUSH, 32'hC000_0000, 16'hC000));
    send_item(mk_item(OP_PUSH, 32'h0000_0008, 16'h0005));
    send_item(mk_item(OP_PUSH, 32'h7FFF_FFFE, 16'h7FFF));
    send_item(mk_item(OP_PUSH, 32'h8000_0001, 16'h8000));
    send_item(mk_item(OP_PUSH, 32'hDEAD_BEEF, 16'h7FFF));
  endtask

  // purge with several matches, purge with none, pops from the head
  task automatic test_purge_and_pop();
    send_item(mk_item(OP_PURGE, 32'hFFFF_FFFF, 16'h0005));
    send_item(mk_item(OP_PURGE, 32'h0, 16'h1234));
    repeat (3) send_item(mk_item(OP_POP, 32'h0, 16'h0));
  endtask

  // random phases that each either fill or drain the queue
  task automatic test_random_traffic();
    bit filling;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        filling      = ($urandom_range(0, 1) == 1);
        tight_stream = ($urandom_range(0, 3) == 0);
      end
      send_item(random_item(filling));
    end
    tight_stream = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    held_count = 0;
    errors     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_order_full();
    test_purge_and_pop();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d push, %0d pop, %0d purge, %0d unused-op transactions; %0d results",
             n_push, n_pop, n_purge, n_nop, n_checked);
    $display("full drops %0d, empty pops %0d, purge hits %0d, peak occupancy %0d, errors %0d",
             n_full, n_empty, n_purge_hits, peak_occupancy, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
